/* src/bdll_pkg.sv */
// shared types and codes for the bounded doubly linked list engine
// no dependencies; imported by the controller, datapath and top level

package bdll_pkg;

	localparam logic [2:0] REQ_INS_HEAD = 3'd0;
	localparam logic [2:0] REQ_INS_TAIL = 3'd1;
	localparam logic [2:0] REQ_DELETE   = 3'd2;
	localparam logic [2:0] REQ_DUMP_FWD = 3'd3;
	localparam logic [2:0] REQ_DUMP_REV = 3'd4;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_FULL      = 2'd1;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
	localparam logic [1:0] STAT_EMPTY     = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALLOC,
		S_LINK,
		S_WALK,
		S_DUMP,
		S_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic       accept;
		logic       walk_start;
		logic       advance;
		logic       scan_clr;
		logic       scan_inc;
		logic       ins_write;
		logic       ins_link;
		logic       del_commit;
		logic       emit_node;
		logic       emit_final;
		logic       sel;
		logic [1:0] code;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic empty_fwd;
		logic empty_rev;
		logic ends_null;
		logic slot_free;
		logic match;
		logic link_null;
		logic walk_end;
		logic out_free;
	} sts_t;

endpackage

/* src/bdll_ctrl.sv */
// request sequencer for the linked list engine
// depends on bdll_pkg; drives bdll_dp through cmd_t and reads sts_t

module bdll_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  logic [2:0]      req_type,
	input  bdll_pkg::sts_t  sts,
	output bdll_pkg::cmd_t  cmd
);
	import bdll_pkg::*;

	state_t     state_q, state_d;
	logic [1:0] code_q, code_d;
	logic       sel_q, sel_d;
	logic       req_sel;

	// forward walk for delete and forward dump, head side for head inserts
	assign req_sel = (req_type == REQ_INS_HEAD) || (req_type == REQ_DELETE) ||
		(req_type == REQ_DUMP_FWD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		code_q <= code_d;
		sel_q  <= sel_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					unique case (req_type)
						REQ_INS_HEAD, REQ_INS_TAIL:
							state_d = sts.full ? S_EMIT : S_ALLOC;
						REQ_DELETE:
							state_d = sts.empty_fwd ? S_EMIT : S_WALK;
						REQ_DUMP_FWD:
							state_d = sts.empty_fwd ? S_EMIT : S_DUMP;
						REQ_DUMP_REV:
							state_d = sts.empty_rev ? S_EMIT : S_DUMP;
						default:
							state_d = S_EMIT;
					endcase
				end
			end
			S_ALLOC: begin
				if (sts.slot_free) begin
					state_d = sts.ends_null ? S_EMIT : S_LINK;
				end
			end
			S_LINK: state_d = S_EMIT;
			S_WALK: begin
				if (sts.match || sts.link_null || sts.walk_end) begin
					state_d = S_EMIT;
				end
			end
			S_DUMP: begin
				if (sts.out_free && (sts.link_null || sts.walk_end)) begin
					state_d = S_IDLE;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		cmd.sel   = sel_q;
		cmd.code  = code_q;
		code_d    = code_q;
		sel_d     = sel_q;
		req_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				cmd.sel   = req_sel;
				if (req_valid) begin
					cmd.accept = 1'b1;
					sel_d      = req_sel;
					code_d     = STAT_OK;
					unique case (req_type)
						REQ_INS_HEAD, REQ_INS_TAIL: begin
							if (sts.full) begin
								code_d = STAT_FULL;
							end else begin
								cmd.scan_clr = 1'b1;
							end
						end
						REQ_DELETE, REQ_DUMP_FWD: begin
							if (sts.empty_fwd) begin
								code_d = STAT_EMPTY;
							end else begin
								cmd.walk_start = 1'b1;
							end
						end
						REQ_DUMP_REV: begin
							if (sts.empty_rev) begin
								code_d = STAT_EMPTY;
							end else begin
								cmd.walk_start = 1'b1;
							end
						end
						default: code_d = STAT_OK;
					endcase
				end
			end
			S_ALLOC: begin
				if (sts.slot_free) begin
					cmd.ins_write = 1'b1;
					code_d        = STAT_OK;
				end else begin
					cmd.scan_inc = 1'b1;
				end
			end
			S_LINK: cmd.ins_link = 1'b1;
			S_WALK: begin
				if (sts.match) begin
					cmd.del_commit = 1'b1;
					code_d         = STAT_OK;
				end else if (sts.link_null || sts.walk_end) begin
					code_d = STAT_NOT_FOUND;
				end else begin
					cmd.advance = 1'b1;
				end
			end
			S_DUMP: begin
				if (sts.out_free) begin
					cmd.emit_node = 1'b1;
					cmd.advance   = !(sts.link_null || sts.walk_end);
				end
			end
			S_EMIT: cmd.emit_final = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

/* src/bdll_dp.sv */
// node memories, list pointers, occupancy map and result register
// depends on bdll_pkg; sequenced by bdll_ctrl

module bdll_dp #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bdll_pkg::cmd_t     cmd,
	output bdll_pkg::sts_t     sts,
	input  logic signed [31:0] item_value,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [1:0]         status,
	output logic signed [31:0] out_value,
	output logic [4:0]         length,
	output logic               last
);
	import bdll_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int IW = $clog2(CAPACITY + 1);
	localparam logic [IW-1:0] NIL = IW'(CAPACITY);

	logic [31:0]   val_mem  [CAPACITY];
	logic [IW-1:0] next_mem [CAPACITY];
	logic [IW-1:0] prev_mem [CAPACITY];

	logic [31:0]   val_rd_q;
	logic [IW-1:0] next_rd_q, prev_rd_q;

	logic [IW-1:0]       head_q, tail_q, total_q, cur_q;
	logic [CAPACITY-1:0] inuse_q;
	logic [AW-1:0]       scan_q, steps_q;
	logic [31:0]         v_q;

	logic          rsp_valid_q, rsp_last_q;
	logic [1:0]    rsp_status_q;
	logic [31:0]   rsp_value_q;
	logic [4:0]    rsp_length_q;

	logic [IW-1:0] link, start_ptr, new_node, rd_ptr;
	logic [AW-1:0] rd_addr;
	logic          p_null, q_null, ends_null, link_null, walk_end, out_free;
	logic [IW-1:0] del_head, del_tail;
	logic [IW+4:0] total_ext;

	logic          next_we, prev_we;
	logic [AW-1:0] next_wa, prev_wa;
	logic [IW-1:0] next_wd, prev_wd;

	assign link      = cmd.sel ? next_rd_q : prev_rd_q;
	assign start_ptr = cmd.sel ? head_q : tail_q;
	assign new_node  = IW'(scan_q);
	assign link_null = (link >= NIL);
	assign walk_end  = (steps_q == AW'(CAPACITY - 1));
	assign ends_null = (head_q >= NIL) || (tail_q >= NIL);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign p_null    = (prev_rd_q >= NIL);
	assign q_null    = (next_rd_q >= NIL);
	assign total_ext = (IW + 5)'(total_q);

	// unlinking can leave one end null; then the whole list is empty
	always_comb begin
		del_head = p_null ? next_rd_q : head_q;
		del_tail = q_null ? prev_rd_q : tail_q;
		if ((del_head >= NIL) || (del_tail >= NIL)) begin
			del_head = NIL;
			del_tail = NIL;
		end
	end

	always_comb begin
		if (cmd.walk_start) begin
			rd_ptr = start_ptr;
		end else if (cmd.advance) begin
			rd_ptr = link;
		end else begin
			rd_ptr = cur_q;
		end
		rd_addr = rd_ptr[AW-1:0];
	end

	always_comb begin
		sts.full      = (total_q >= NIL);
		sts.empty_fwd = (total_q == '0) || (head_q >= NIL);
		sts.empty_rev = (total_q == '0) || (tail_q >= NIL);
		sts.ends_null = ends_null;
		sts.slot_free = !inuse_q[scan_q];
		sts.match     = (val_rd_q == v_q);
		sts.link_null = link_null;
		sts.walk_end  = walk_end;
		sts.out_free  = out_free;
	end

	// link memory write ports
	always_comb begin
		next_we = 1'b0;
		next_wa = scan_q;
		next_wd = NIL;
		prev_we = 1'b0;
		prev_wa = scan_q;
		prev_wd = NIL;
		priority if (cmd.ins_write) begin
			next_we = 1'b1;
			prev_we = 1'b1;
			next_wd = (ends_null || !cmd.sel) ? NIL : head_q;
			prev_wd = (ends_null || cmd.sel) ? NIL : tail_q;
		end else if (cmd.ins_link) begin
			if (cmd.sel) begin
				prev_we = 1'b1;
				prev_wa = head_q[AW-1:0];
				prev_wd = new_node;
			end else begin
				next_we = 1'b1;
				next_wa = tail_q[AW-1:0];
				next_wd = new_node;
			end
		end else if (cmd.del_commit) begin
			next_we = !p_null;
			next_wa = prev_rd_q[AW-1:0];
			next_wd = next_rd_q;
			prev_we = !q_null;
			prev_wa = next_rd_q[AW-1:0];
			prev_wd = prev_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins_write) begin
			val_mem[scan_q] <= v_q;
		end
		val_rd_q <= val_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		next_rd_q <= next_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (prev_we) begin
			prev_mem[prev_wa] <= prev_wd;
		end
		prev_rd_q <= prev_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= NIL;
			tail_q  <= NIL;
			inuse_q <= '0;
			total_q <= '0;
		end else begin
			priority if (cmd.ins_write) begin
				inuse_q[scan_q] <= 1'b1;
				total_q         <= total_q + IW'(1);
				if (ends_null) begin
					head_q <= new_node;
					tail_q <= new_node;
				end
			end else if (cmd.ins_link) begin
				if (cmd.sel) begin
					head_q <= new_node;
				end else begin
					tail_q <= new_node;
				end
			end else if (cmd.del_commit) begin
				inuse_q[cur_q[AW-1:0]] <= 1'b0;
				total_q                <= total_q - IW'(1);
				head_q                 <= del_head;
				tail_q                 <= del_tail;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			v_q <= item_value;
		end
		if (cmd.scan_clr) begin
			scan_q <= '0;
		end else if (cmd.scan_inc) begin
			scan_q <= scan_q + AW'(1);
		end
		if (cmd.walk_start) begin
			cur_q   <= start_ptr;
			steps_q <= '0;
		end else if (cmd.advance) begin
			cur_q   <= link;
			steps_q <= steps_q + AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit_node || cmd.emit_final) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_node) begin
			rsp_status_q <= STAT_OK;
			rsp_value_q  <= val_rd_q;
			rsp_length_q <= total_ext[4:0];
			rsp_last_q   <= link_null || walk_end;
		end else if (cmd.emit_final) begin
			rsp_status_q <= cmd.code;
			rsp_value_q  <= '0;
			rsp_length_q <= total_ext[4:0];
			rsp_last_q   <= 1'b1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status    = rsp_status_q;
	assign out_value = rsp_value_q;
	assign length    = rsp_length_q;
	assign last      = rsp_last_q;

endmodule

/* src/bounded_doubly_linked_list.sv */
// insert: an empty list is written in S_ALLOC and answered from S_EMIT; otherwise the free-node
// scan steps past used slots in S_ALLOC, S_LINK joins the node, then S_EMIT; a full store
// goes straight to S_EMIT. delete walks the list until a match or its end; an empty list goes
// straight to S_EMIT. dump emits one node a cycle while the output is not stalled; stalls hold all
// responses. one request at a time, the next one taken once its final result has been issued
// reset empties the list (ends, map, count); node memories kept; uses bdll_ctrl, bdll_dp

module bounded_doubly_linked_list #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [2:0]         req_type,
	input  logic signed [31:0] item_value,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [1:0]         status,
	output logic signed [31:0] out_value,
	output logic [4:0]         length,
	output logic               last
);
	import bdll_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bdll_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req_type),
		.sts       (sts),
		.cmd       (cmd)
	);

	bdll_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.item_value (item_value),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.status     (status),
		.out_value  (out_value),
		.length     (length),
		.last       (last)
	);

endmodule

/* src/bdll_checker.sv */
// port-level checks for the linked list engine, bound to the top level
// depends on bdll_pkg and bounded_doubly_linked_list

module bdll_checker #(
	parameter int CAPACITY = 16
) (
	input logic               clk,
	input logic               arst_n,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input logic [1:0]         status,
	input logic signed [31:0] out_value,
	input logic [4:0]         length,
	input logic               last
);
	import bdll_pkg::*;

	// a held response keeps its contents
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(out_value) &&
		$stable(length) && $stable(last))
		else $error("response changed while stalled");

	// error statuses are single-response requests with no value
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != STAT_OK) |-> last && (out_value == 0))
		else $error("error status without last or with a value");

	// full store reports the capacity as length
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == STAT_FULL) |-> length == 5'(CAPACITY))
		else $error("full status with wrong length");

	// empty list reports zero length
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == STAT_EMPTY) |-> length == 5'd0)
		else $error("empty status with nonzero length");

endmodule

bind bounded_doubly_linked_list bdll_checker #(
	.CAPACITY (CAPACITY)
) u_bdll_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.status    (status),
	.out_value (out_value),
	.length    (length),
	.last      (last)
);
